// File: rtl/pba_pkg.sv
// Shared constants, types and the helper function of the port bitmap allocator.
package pba_pkg;

    localparam int SLOTS        = 32768;
    localparam int WORD_BITS    = 32;
    localparam int RANDOM_DRAWS = 16;

    localparam int PORT_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int RNG_W     = 32;
    localparam int DRAW_W    = 31;
    localparam int CAND_W    = 15;
    localparam int PORT_BASE = 32768;

    localparam int MAP_WORDS = (SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int OFF_W     = $clog2(WORD_BITS);
    localparam int VISIT_W   = $clog2(MAP_WORDS + 1);
    localparam int DCNT_W    = (RANDOM_DRAWS > 1) ? $clog2(RANDOM_DRAWS) : 1;
    localparam int LAST_BITS = SLOTS - (MAP_WORDS - 1) * WORD_BITS;

    localparam logic [RNG_W-1:0] LFSR_TAPS = 32'hD000_0001;
    localparam logic [RNG_W-1:0] SEED_INIT = 32'h0000_0001;

    localparam logic MODE_RESERVE = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [ADDR_W-1:0]    t_addr;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_REL_WR,
        S_DRAW,
        S_PROBE_RED,
        S_PROBE_TEST,
        S_SCAN_DRAW,
        S_SCAN_RED,
        S_SCAN_TEST,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic  rd_en;
        t_addr rd_addr;
        logic  wr_en;
        t_addr wr_addr;
        t_word wr_data;
    } t_map_req;

    typedef struct packed {
        logic [PORT_W-1:0] port_out;
        t_status           status;
    } t_result;

    // One step of the Galois generator.
    function automatic logic [RNG_W-1:0] lfsr_step(input logic [RNG_W-1:0] s);
        return (s >> 1) ^ (s[0] ? LFSR_TAPS : '0);
    endfunction

endpackage

// File: rtl/pba_if.sv
// Valid/ready channel interfaces for request and result words.
interface pba_in_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [pba_pkg::PORT_W-1:0] port;

    modport source (output valid, output mode, output port, input ready);
    modport sink   (input valid, input mode, input port, output ready);
endinterface

interface pba_out_if;
    logic                         valid;
    logic                         ready;
    logic [pba_pkg::PORT_W-1:0]   port_out;
    logic [pba_pkg::STATUS_W-1:0] status;

    modport source (output valid, output port_out, output status, input ready);
    modport sink   (input valid, input port_out, input status, output ready);
endinterface

// File: rtl/pba_lfsr.sv
// Pseudo-random generator state with seed load.
module pba_lfsr (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_seed_we,
    input  logic [pba_pkg::RNG_W-1:0] i_seed,
    input  logic                      i_step,
    output logic [pba_pkg::RNG_W-1:0] o_next
);
    import pba_pkg::*;

    logic [RNG_W-1:0] r_rng;

    assign o_next = lfsr_step(r_rng);

    // A zero seed would lock the generator, so it loads one instead.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rng <= SEED_INIT;
        end else if (i_seed_we) begin
            r_rng <= (i_seed != '0) ? i_seed : SEED_INIT;
        end else if (i_step) begin
            r_rng <= o_next;
        end
    end
endmodule

// File: rtl/pba_map.sv
// Slot bitmap memory with one write port and one registered read port.
module pba_map (
    input  logic              i_clk,
    input  pba_pkg::t_map_req i_req,
    output pba_pkg::t_word    o_rd_data
);
    import pba_pkg::*;

    t_word r_mem [MAP_WORDS];
    t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// File: rtl/pba_seq.sv
// Sequencer: clearing pass, random probes, word scan and release.
module pba_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_mode,
    input  logic [pba_pkg::PORT_W-1:0] i_port,
    input  logic                       i_out_free,
    output logic                       o_res_valid,
    output pba_pkg::t_result           o_res,
    output logic                       o_step,
    input  logic [pba_pkg::RNG_W-1:0]  i_rng_next,
    output pba_pkg::t_map_req          o_map_req,
    input  pba_pkg::t_word             i_rd_data
);
    import pba_pkg::*;

    localparam t_word LAST_MASK = ~(t_word'('1) << LAST_BITS);

    t_state                r_state, n_state;
    t_addr                 r_clr_addr, n_clr_addr;
    logic [CAND_W-1:0]     r_cand, n_cand;
    logic [DRAW_W-1:0]     r_rand, n_rand;
    logic [DCNT_W-1:0]     r_draw_cnt, n_draw_cnt;
    t_addr                 r_scan_addr, n_scan_addr;
    logic                  r_first, n_first;
    logic [VISIT_W-1:0]    r_visit, n_visit;
    t_result               r_res, n_res;

    logic [PORT_W-1:0]     rel_slot;
    logic                  rel_in_range;
    logic                  cand_big;
    t_addr                 cand_addr;
    logic [OFF_W-1:0]      cand_off;
    logic                  cand_free;
    logic [DRAW_W-1:0]     rand_shift;
    logic                  last_draw;
    t_word                 scan_free;
    logic [OFF_W-1:0]      scan_idx;
    t_addr                 scan_next;
    logic                  scan_last_word;
    logic                  last_visit;

    // Lowest set bit of the word; the search runs over independent bits.
    function automatic logic [OFF_W-1:0] first_set(input t_word v);
        logic [OFF_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = OFF_W'(i);
            end
        end
        return idx;
    endfunction

    assign rel_slot     = i_port - PORT_W'(PORT_BASE);
    assign rel_in_range = (i_port >= PORT_W'(PORT_BASE)) &&
                          ({1'b0, rel_slot} < (PORT_W + 1)'(SLOTS));
    assign cand_big     = ({1'b0, r_cand} >= (CAND_W + 1)'(SLOTS));
    assign cand_addr    = ADDR_W'(r_cand >> OFF_W);
    assign cand_off     = r_cand[OFF_W-1:0];
    assign cand_free    = !i_rd_data[cand_off];
    assign rand_shift   = r_rand >> 16;
    assign last_draw    = (r_draw_cnt == DCNT_W'(RANDOM_DRAWS - 1));

    assign scan_last_word = (r_scan_addr == ADDR_W'(MAP_WORDS - 1));
    assign scan_free      = ~i_rd_data
                          & (scan_last_word ? LAST_MASK : t_word'('1))
                          & (r_first ? (t_word'('1) << cand_off) : t_word'('1));
    assign scan_idx       = first_set(scan_free);
    assign scan_next      = scan_last_word ? '0 : r_scan_addr + 1'b1;
    assign last_visit     = (r_visit == VISIT_W'(MAP_WORDS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand      <= n_cand;
        r_rand      <= n_rand;
        r_draw_cnt  <= n_draw_cnt;
        r_scan_addr <= n_scan_addr;
        r_first     <= n_first;
        r_visit     <= n_visit;
        r_res       <= n_res;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == ADDR_W'(MAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_mode == MODE_RESERVE) begin
                        n_state = S_DRAW;
                    end else if (rel_in_range) begin
                        n_state = S_REL_WR;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_REL_WR:    n_state = S_FINISH;
            S_DRAW:      n_state = S_PROBE_RED;
            S_PROBE_RED: begin
                if (!cand_big) begin
                    n_state = S_PROBE_TEST;
                end
            end
            S_PROBE_TEST: begin
                if (cand_free) begin
                    n_state = S_FINISH;
                end else if (rand_shift != '0) begin
                    n_state = S_PROBE_RED;
                end else if (last_draw) begin
                    n_state = S_SCAN_DRAW;
                end else begin
                    n_state = S_DRAW;
                end
            end
            S_SCAN_DRAW: n_state = S_SCAN_RED;
            S_SCAN_RED: begin
                if (!cand_big) begin
                    n_state = S_SCAN_TEST;
                end
            end
            S_SCAN_TEST: begin
                if ((scan_free != '0) || last_visit) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and datapath.
    always_comb begin
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_res       = r_res;
        o_step      = 1'b0;
        o_map_req   = '0;
        n_clr_addr  = r_clr_addr;
        n_cand      = r_cand;
        n_rand      = r_rand;
        n_draw_cnt  = r_draw_cnt;
        n_scan_addr = r_scan_addr;
        n_first     = r_first;
        n_visit     = r_visit;
        n_res       = r_res;
        unique case (r_state)
            S_CLEAR: begin
                o_map_req.wr_en   = 1'b1;
                o_map_req.wr_addr = r_clr_addr;
                o_map_req.wr_data = '0;
                n_clr_addr        = r_clr_addr + 1'b1;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                n_draw_cnt = '0;
                n_cand     = CAND_W'(rel_slot);
                n_res      = '{port_out: '0, status: ST_RANGE};
                o_map_req.rd_en   = i_in_valid && (i_mode == MODE_RELEASE);
                o_map_req.rd_addr = ADDR_W'(rel_slot >> OFF_W);
            end
            S_REL_WR: begin
                o_map_req.wr_en   = 1'b1;
                o_map_req.wr_addr = cand_addr;
                o_map_req.wr_data = i_rd_data & ~(t_word'(1) << cand_off);
                n_res             = '{port_out: '0, status: ST_DONE};
            end
            S_DRAW, S_SCAN_DRAW: begin
                o_step = 1'b1;
                n_rand = i_rng_next[DRAW_W-1:0];
                n_cand = i_rng_next[CAND_W-1:0];
            end
            S_PROBE_RED, S_SCAN_RED: begin
                if (cand_big) begin
                    n_cand = r_cand - CAND_W'(SLOTS);
                end else begin
                    o_map_req.rd_en   = 1'b1;
                    o_map_req.rd_addr = cand_addr;
                    n_scan_addr       = cand_addr;
                    n_first           = 1'b1;
                    n_visit           = '0;
                end
            end
            S_PROBE_TEST: begin
                if (cand_free) begin
                    o_map_req.wr_en   = 1'b1;
                    o_map_req.wr_addr = cand_addr;
                    o_map_req.wr_data = i_rd_data | (t_word'(1) << cand_off);
                    n_res = '{port_out: PORT_W'(PORT_BASE) + PORT_W'(r_cand),
                              status: ST_DONE};
                end else begin
                    n_rand = rand_shift;
                    n_cand = rand_shift[CAND_W-1:0];
                    if (rand_shift == '0) begin
                        n_draw_cnt = r_draw_cnt + 1'b1;
                    end
                end
            end
            S_SCAN_TEST: begin
                if (scan_free != '0) begin
                    o_map_req.wr_en   = 1'b1;
                    o_map_req.wr_addr = r_scan_addr;
                    o_map_req.wr_data = i_rd_data | (t_word'(1) << scan_idx);
                    n_res = '{port_out: PORT_W'(PORT_BASE) +
                                        PORT_W'({r_scan_addr, scan_idx}),
                              status: ST_DONE};
                end else if (last_visit) begin
                    n_res = '{port_out: '0, status: ST_FULL};
                end else begin
                    o_map_req.rd_en   = 1'b1;
                    o_map_req.rd_addr = scan_next;
                    n_scan_addr       = scan_next;
                    n_first           = 1'b0;
                    n_visit           = r_visit + 1'b1;
                end
            end
            S_FINISH: begin
                o_res_valid = i_out_free;
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
    end
endmodule

// File: rtl/port_bitmap_allocator.sv
// Top level of the port bitmap allocator: channels, generator, bitmap and sequencer.

// The allocator hands out local port numbers 32768 + slot from a bitmap of
// SLOTS slots (one bit per slot, WORD_BITS slots per memory word, set means
// in use). A reserve word (mode 0) draws up to RANDOM_DRAWS values from an
// internal 32-bit Galois LFSR; each draw probes the slot in its low 15 bits
// and, when bits 16 to 30 are nonzero, the slot they give, and the first
// free slot is claimed. When every probe misses, one more draw picks a start
// slot and the map is scanned upward one word per cycle, wrapping once over
// the whole map; status 1 with port 0 means the map is full. A release word
// (mode 1) clears the slot of the given port, or returns status 2 when the
// port lies outside 32768 to 32768 + SLOTS - 1. Writing i_cfg_data with
// i_cfg_we reseeds the generator (a zero seed loads one); write it only
// while no word is in flight. After reset the bitmap is cleared by a pass
// over all MAP_WORDS words (1024 by default) with i_in.ready low. The block
// then takes one word at a time through a single bitmap memory, every test
// being a memory read, followed by a write when it claims or frees a slot.
// A release reads its word on acceptance and writes it back in S_REL_WR; a
// reservation passes S_DRAW, S_PROBE_RED and S_PROBE_TEST for each draw,
// and S_PROBE_RED and S_PROBE_TEST again for a second probe, and a scan
// S_SCAN_DRAW, S_SCAN_RED and then S_SCAN_TEST per word. The next word is
// accepted while a result still waits in the output register.
module port_bitmap_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    pba_in_if.sink                      i_in,
    pba_out_if.source                   o_out,
    input  logic                        i_cfg_we,
    input  logic [pba_pkg::RNG_W-1:0]   i_cfg_data
);
    import pba_pkg::*;

    logic             step;
    logic [RNG_W-1:0] rng_next;
    t_map_req         map_req;
    t_word            rd_data;
    logic             out_free;
    logic             res_valid;
    t_result          res;

    logic              r_out_valid;
    logic [PORT_W-1:0] r_out_port;
    t_status           r_out_status;

    pba_lfsr u_lfsr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_seed_we (i_cfg_we),
        .i_seed    (i_cfg_data),
        .i_step    (step),
        .o_next    (rng_next)
    );

    pba_map u_map (
        .i_clk     (i_clk),
        .i_req     (map_req),
        .o_rd_data (rd_data)
    );

    pba_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_mode      (i_in.mode),
        .i_port      (i_in.port),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_step      (step),
        .i_rng_next  (rng_next),
        .o_map_req   (map_req),
        .i_rd_data   (rd_data)
    );

    // The result register is free when it is empty or being taken now.
    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_port   <= res.port_out;
            r_out_status <= res.status;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.port_out = r_out_port;
    assign o_out.status   = r_out_status;
endmodule

// File: rtl/pba_checker.sv
// Port-level checks of the port bitmap allocator and their binding.
module pba_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [pba_pkg::PORT_W-1:0]   i_out_port,
    input logic [pba_pkg::STATUS_W-1:0] i_out_status
);
    import pba_pkg::*;

    // A granted port always lies in the upper half and comes with success.
    a_port_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_port != '0)) |-> (i_out_port[PORT_W-1] &&
                                                 (i_out_status == ST_DONE)))
        else $error("granted port without done status or below base");

    // Failure results never carry a port.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_status != ST_DONE)) |-> (i_out_port == '0))
        else $error("failure result carries a port");

    // One word at a time: no acceptance in the cycle after an acceptance.
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request accepted while the previous one is busy");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_port) && $stable(i_out_status)))
        else $error("result changed while stalled");
endmodule

bind port_bitmap_allocator pba_checker u_pba_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_port   (o_out.port_out),
    .i_out_status (o_out.status)
);
